// ===== rtl/cstb_pkg.sv =====
// shared types and constants for the clipped sprite tint blit
// no dependencies; imported by every rtl file of the block
`default_nettype none

package cstb_pkg;

   localparam int PIXEL_W     = 16;
   localparam int POS_W       = 11;
   localparam int SIZE_W      = 10;
   localparam int TINT_W      = 2;
   localparam int COUNT_W     = 10;
   localparam int COORD_W     = 13;
   localparam int WIN_X_W     = 9;
   localparam int WIN_Y_W     = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_X         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_Y         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPRITE_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPRITE_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TINT_MODE     = 3'd4;

   // tint codes
   localparam logic [TINT_W-1:0] TINT_PASS  = 2'd0;
   localparam logic [TINT_W-1:0] TINT_RED   = 2'd1;
   localparam logic [TINT_W-1:0] TINT_GREEN = 2'd2;

   localparam logic [COUNT_W-1:0] ROW_MAX = '1;

   // pixel held in the input stage with its place in the sprite
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [COUNT_W-1:0] col;
      logic [COUNT_W-1:0] row;
   } beat_type;

   // clipped screen window in signed screen coordinates
   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      logic                      nonempty;
   } window_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] out_pixel;
      logic [WIN_X_W-1:0] win_left;
      logic [WIN_Y_W-1:0] win_top;
      logic [WIN_X_W-1:0] win_right;
      logic [WIN_Y_W-1:0] win_bottom;
      logic               last_visible;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/cstb_channels.sv =====
// valid/ready channel interfaces for pixel beats in and result beats out
// depends on cstb_pkg for field widths
`default_nettype none

interface cstb_req_if
   import cstb_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] src_pixel;
   logic               frame_start;

   modport source (output valid, output src_pixel, output frame_start, input ready);
   modport sink   (input valid, input src_pixel, input frame_start, output ready);
endinterface

interface cstb_rsp_if
   import cstb_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] out_pixel;
   logic [WIN_X_W-1:0] win_left;
   logic [WIN_Y_W-1:0] win_top;
   logic [WIN_X_W-1:0] win_right;
   logic [WIN_Y_W-1:0] win_bottom;
   logic               last_visible;

   modport source (output valid, output out_pixel, output win_left, output win_top,
                   output win_right, output win_bottom, output last_visible,
                   input ready);
   modport sink   (input valid, input out_pixel, input win_left, input win_top,
                   input win_right, input win_bottom, input last_visible,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/cstb_window.sv =====
// clipped screen window, recomputed from the placement registers each cycle
// depends on cstb_pkg
`default_nettype none

module cstb_window
   import cstb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  wire logic                    clock,
   input  wire logic signed [POS_W-1:0] pos_x,
   input  wire logic signed [POS_W-1:0] pos_y,
   input  wire logic [SIZE_W-1:0]       sprite_width,
   input  wire logic [SIZE_W-1:0]       sprite_height,
   output window_type                   win_ff
);

   localparam logic signed [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_WIDTH - 1);
   localparam logic signed [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_HEIGHT - 1);

   logic signed [COORD_W-1:0] px, py, w, h, x_end, y_end;
   window_type                win_in;

   always_comb begin
      px    = COORD_W'(pos_x);
      py    = COORD_W'(pos_y);
      w     = signed'({{(COORD_W-SIZE_W){1'b0}}, sprite_width});
      h     = signed'({{(COORD_W-SIZE_W){1'b0}}, sprite_height});
      x_end = px + w - 13'sd1;
      y_end = py + h - 13'sd1;
      win_in.x1 = px[COORD_W-1] ? '0 : px;
      win_in.y1 = py[COORD_W-1] ? '0 : py;
      win_in.x2 = (x_end > X_MAX) ? X_MAX : x_end;
      win_in.y2 = (y_end > Y_MAX) ? Y_MAX : y_end;
      win_in.nonempty = (win_in.x1 <= win_in.x2) && (win_in.y1 <= win_in.y2);
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

// ===== rtl/cstb_position.sv =====
// raster position counters and the input stage register
// depends on cstb_pkg
`default_nettype none

module cstb_position
   import cstb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [PIXEL_W-1:0] src_pixel,
   input  wire logic               frame_start,
   input  wire logic [SIZE_W-1:0]  sprite_width,
   input  wire logic               advance,
   output beat_type                stage_ff,
   output logic                    stage_valid_ff
);

   logic [COUNT_W-1:0] col_ff, row_ff, col_in, row_in, col_cur, row_cur;
   logic [COUNT_W:0]   col_inc;
   logic               stage_valid_in;
   beat_type           stage_in;

   always_comb begin
      col_cur = frame_start ? '0 : col_ff;
      row_cur = frame_start ? '0 : row_ff;
      col_inc = {1'b0, col_cur} + 11'd1;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (col_inc >= {1'b0, sprite_width}) begin
            col_in = '0;
            row_in = (row_cur == ROW_MAX) ? row_cur : row_cur + 10'd1;
         end else begin
            col_in = col_inc[COUNT_W-1:0];
            row_in = row_cur;
         end
      end
      stage_in.pixel = src_pixel;
      stage_in.col   = col_cur;
      stage_in.row   = row_cur;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   a_frame_start_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_start) |=> (stage_valid_ff && stage_ff.col == '0 && stage_ff.row == '0))
      else $error("frame start beat not placed at sprite origin");

   a_row_saturates: assert property (@(posedge clock) disable iff (reset)
      (accept && !frame_start && row_ff == ROW_MAX) |=> (row_ff == ROW_MAX))
      else $error("row counter wrapped past its ceiling");

endmodule

`default_nettype wire

// ===== rtl/cstb_emit.sv =====
// visibility test, tint and result register
// depends on cstb_pkg
`default_nettype none

module cstb_emit
   import cstb_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    stage_valid,
   input  wire beat_type                stage,
   input  wire window_type              win,
   input  wire logic signed [POS_W-1:0] pos_x,
   input  wire logic signed [POS_W-1:0] pos_y,
   input  wire logic [SIZE_W-1:0]       sprite_width,
   input  wire logic [SIZE_W-1:0]       sprite_height,
   input  wire logic [TINT_W-1:0]       tint_mode,
   input  wire logic                    out_ready,
   output logic                         advance,
   output logic                         out_valid_ff,
   output result_type                   result_ff
);

   function automatic logic [PIXEL_W-1:0] apply_tint(input logic [PIXEL_W-1:0] p,
                                                     input logic [TINT_W-1:0] mode);
      logic [4:0] r;
      logic [5:0] g;
      logic [4:0] b;
      logic [PIXEL_W-1:0] q;
      r = p[15:11];
      g = p[10:5];
      b = p[4:0];
      case (mode)
         TINT_RED:   q = {r[3:0], 1'b0, 1'b0, g[5:1], b};
         TINT_GREEN: q = {2'b00, r[4:2], g, 1'b0, b[4:1]};
         default:    q = p;
      endcase
      return q;
   endfunction

   logic signed [COORD_W-1:0] sx, sy;
   logic                      visible, out_valid_in;
   result_type                result_in;

   always_comb begin
      sx = COORD_W'(pos_x) + signed'({{(COORD_W-COUNT_W){1'b0}}, stage.col});
      sy = COORD_W'(pos_y) + signed'({{(COORD_W-COUNT_W){1'b0}}, stage.row});
      visible = win.nonempty && (stage.col < sprite_width) && (stage.row < sprite_height)
                && (sx >= win.x1) && (sx <= win.x2) && (sy >= win.y1) && (sy <= win.y2);
      advance = !out_valid_ff || out_ready;
      result_in.out_pixel    = apply_tint(stage.pixel, tint_mode);
      result_in.win_left     = win.x1[WIN_X_W-1:0];
      result_in.win_top      = win.y1[WIN_Y_W-1:0];
      result_in.win_right    = win.x2[WIN_X_W-1:0];
      result_in.win_bottom   = win.y2[WIN_Y_W-1:0];
      result_in.last_visible = (sx == win.x2) && (sy == win.y2);
      out_valid_in = advance ? (stage_valid && visible) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && stage_valid && visible) begin
         result_ff <= result_in;
      end
   end

   a_no_result_from_nothing: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff && !stage_valid) |=> !out_valid_ff)
      else $error("result appeared with no pixel in flight");

endmodule

`default_nettype wire

// ===== rtl/clipped_sprite_tint_blit.sv =====
// top level of the clipped sprite tint blit: csr registers and pipeline wiring
// depends on cstb_pkg, cstb_channels, cstb_window, cstb_position, cstb_emit
`default_nettype none

// Sprite pixels arrive in raster order, one per req beat, and frame_start
// restarts the column and row counters at the sprite origin. Each pixel is
// placed at (pos_x + column, pos_y + row); pixels off the screen are dropped,
// visible ones leave on rsp tinted per tint_mode with the clipped window and
// a flag on the bottom-right visible pixel. The block takes one beat per
// clock while rsp_if does not stall: a beat passes an input stage register
// and a result register, and req_if.ready falls only while a result waits
// on rsp_if with the input stage already full. The window is recomputed
// from the csr registers every cycle; write them while the block is idle.
module clipped_sprite_tint_blit
   import cstb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   cstb_req_if.sink                    req_if,
   cstb_rsp_if.source                  rsp_if,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   // placement and tint registers
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic [SIZE_W-1:0]       sprite_width_ff, sprite_height_ff;
   logic [TINT_W-1:0]       tint_mode_ff;

   window_type win;
   beat_type   stage;
   result_type result;
   logic       stage_valid, advance, accept, out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff         <= '0;
         pos_y_ff         <= '0;
         sprite_width_ff  <= 10'd1;
         sprite_height_ff <= 10'd1;
         tint_mode_ff     <= TINT_PASS;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POS_X:         pos_x_ff         <= signed'(csr_write_data[POS_W-1:0]);
            CSR_POS_Y:         pos_y_ff         <= signed'(csr_write_data[POS_W-1:0]);
            CSR_SPRITE_WIDTH:  sprite_width_ff  <= csr_write_data[SIZE_W-1:0];
            CSR_SPRITE_HEIGHT: sprite_height_ff <= csr_write_data[SIZE_W-1:0];
            CSR_TINT_MODE:     tint_mode_ff     <= csr_write_data[TINT_W-1:0];
            default: ;  // unmapped index, write ignored
         endcase
      end
   end

   // input stage takes a beat when empty or when it hands its beat on
   assign req_if.ready = !stage_valid || advance;
   assign accept       = req_if.valid && req_if.ready;

   cstb_window #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_window (
      .clock         (clock),
      .pos_x         (pos_x_ff),
      .pos_y         (pos_y_ff),
      .sprite_width  (sprite_width_ff),
      .sprite_height (sprite_height_ff),
      .win_ff        (win)
   );

   cstb_position u_position (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .src_pixel      (req_if.src_pixel),
      .frame_start    (req_if.frame_start),
      .sprite_width   (sprite_width_ff),
      .advance        (advance),
      .stage_ff       (stage),
      .stage_valid_ff (stage_valid)
   );

   cstb_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (stage_valid),
      .stage         (stage),
      .win           (win),
      .pos_x         (pos_x_ff),
      .pos_y         (pos_y_ff),
      .sprite_width  (sprite_width_ff),
      .sprite_height (sprite_height_ff),
      .tint_mode     (tint_mode_ff),
      .out_ready     (rsp_if.ready),
      .advance       (advance),
      .out_valid_ff  (out_valid),
      .result_ff     (result)
   );

   // result beat
   assign rsp_if.valid        = out_valid;
   assign rsp_if.out_pixel    = result.out_pixel;
   assign rsp_if.win_left     = result.win_left;
   assign rsp_if.win_top      = result.win_top;
   assign rsp_if.win_right    = result.win_right;
   assign rsp_if.win_bottom   = result.win_bottom;
   assign rsp_if.last_visible = result.last_visible;

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_if.valid && !rsp_if.ready && stage_valid))
      else $error("input held off without a stalled result");

   a_stage_drains: assert property (@(posedge clock) disable iff (reset)
      (stage_valid && !accept && advance) |=> !stage_valid)
      else $error("input stage kept a beat it had handed on");

endmodule

`default_nettype wire
